>>> src/mkls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Material keyword line scanner package
// Shared types, constants and helpers for the material library scanner.
// ----------------------------------------------------------------------------
package mkls_pkg;

    localparam int NAME_CAPACITY = 256;
    localparam int OFFSET_BITS   = 32;
    localparam int LEN_BITS      = $clog2(NAME_CAPACITY);
    localparam int KEYWORD_LEN   = 6;
    localparam int KI_BITS       = 3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_HASH  = 8'h23;

    typedef enum logic [1:0] {
        PH_KEYWORD,
        PH_SPACE,
        PH_NAME,
        PH_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE,
        EV_COMMIT,
        EV_DISCARD
    } t_event;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_scan_in;

    typedef struct packed {
        logic        name_byte_valid;
        logic [7:0]  name_byte;
        logic [1:0]  record_event;
        logic [31:0] record_offset;
        logic [7:0]  name_length;
        logic        prior_size_valid;
        logic [31:0] prior_size;
        logic        final_size_valid;
        logic [31:0] final_size;
    } t_scan_out;

    // Characters of the keyword "newmtl".
    function automatic logic [7:0] keyword_char(input logic [KI_BITS-1:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h6E;
            3'd1:    ch = 8'h65;
            3'd2:    ch = 8'h77;
            3'd3:    ch = 8'h6D;
            3'd4:    ch = 8'h74;
            3'd5:    ch = 8'h6C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

>>> src/material_keyword_line_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Material keyword line scanner
// Scans material library text one byte per request, streams material name
// bytes and reports committed names with their line offsets and sizes.
// ----------------------------------------------------------------------------
// Each accepted request is held in the input register and its result in the result register.
// Throughput: one byte per cycle while the output is not stalled; the scan state
// updates in a single pass from the input register to the result register.
// Reset: synchronous, returns the scanner to keyword matching at offset 0.
// The final byte of a text also returns all scan state to its reset value.
module material_keyword_line_scanner_unit
    import mkls_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_scan_in  i_req,
    output logic      o_valid,
    input  logic      i_stall,
    output t_scan_out o_rsp
);

    logic                   r_in_valid;
    t_scan_in               r_in;
    logic                   r_out_valid;
    t_scan_out              r_rsp;
    t_scan_out              n_rsp;

    t_phase                 r_phase, n_phase;
    logic [KI_BITS-1:0]     r_ki, n_ki;
    logic [LEN_BITS-1:0]    r_cl, n_cl;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_lso, n_lso;
    logic [OFFSET_BITS-1:0] r_lro, n_lro;
    logic                   r_hr, n_hr;

    logic                   out_free;
    logic                   fire;
    logic [7:0]             b;
    logic                   eot;
    logic                   is_ws;
    logic                   is_sep;
    logic                   kw_match;
    logic                   enter_name;
    logic                   name_end;
    logic                   name_byte;
    logic                   overflow;
    logic                   commit;
    logic [LEN_BITS-1:0]    cl_eff;
    logic [LEN_BITS:0]      name_len;
    logic [LEN_BITS-1:0]    commit_len;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] lro_after;

    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign o_valid  = r_out_valid;
    assign o_rsp    = r_rsp;

    assign b          = r_in.text_byte;
    assign eot        = r_in.end_of_text;
    assign is_sep     = (b == CH_SPACE) || (b == CH_TAB);
    assign is_ws      = is_sep || (b == CH_CR) || (b == CH_LF);
    assign kw_match   = (r_ki < KI_BITS'(KEYWORD_LEN)) && (b == keyword_char(r_ki));
    assign enter_name = (r_phase == PH_NAME) || ((r_phase == PH_SPACE) && !is_ws);
    assign name_end   = enter_name && (is_ws || (b == CH_HASH));
    assign name_byte  = enter_name && !name_end;
    assign cl_eff     = (r_phase == PH_NAME) ? r_cl : '0;
    assign name_len   = {1'b0, cl_eff} + 1'b1;
    assign overflow   = name_byte && (32'(name_len) >= 32'(NAME_CAPACITY));
    assign commit     = name_end || (name_byte && !overflow && eot);
    assign commit_len = name_end ? cl_eff : name_len[LEN_BITS-1:0];
    assign pos_inc    = r_pos + 1'b1;
    assign lro_after  = commit ? r_lso : r_lro;

    always_comb begin
        n_phase = r_phase;
        n_ki    = r_ki;
        n_cl    = r_cl;
        n_lso   = r_lso;
        n_lro   = r_lro;
        n_hr    = r_hr;
        n_pos   = pos_inc;
        case (r_phase)
            PH_KEYWORD: begin
                if (r_ki == '0) begin
                    n_lso = r_pos;
                end
                if (r_ki < KI_BITS'(KEYWORD_LEN)) begin
                    if (kw_match) begin
                        n_ki = r_ki + 1'b1;
                    end else begin
                        n_phase = (b == CH_LF) ? PH_KEYWORD : PH_SKIP;
                        n_ki    = '0;
                    end
                end else if (is_sep) begin
                    n_phase = PH_SPACE;
                    n_ki    = '0;
                end else begin
                    n_phase = (b == CH_LF) ? PH_KEYWORD : PH_SKIP;
                    n_ki    = '0;
                end
            end
            PH_SPACE: begin
                if (!is_ws) begin
                    n_phase = PH_NAME;
                end
            end
            PH_SKIP: begin
                n_phase = (b == CH_LF) ? PH_KEYWORD : PH_SKIP;
                n_ki    = '0;
            end
            default: ;
        endcase
        if (name_end) begin
            n_cl    = '0;
            n_phase = (b == CH_LF) ? PH_KEYWORD : PH_SKIP;
            n_ki    = '0;
        end else if (overflow) begin
            n_cl    = '0;
            n_phase = PH_SKIP;
        end else if (name_byte) begin
            n_cl = name_len[LEN_BITS-1:0];
        end
        if (commit) begin
            n_lro = r_lso;
            n_hr  = 1'b1;
        end
        if (eot) begin
            n_phase = PH_KEYWORD;
            n_ki    = '0;
            n_cl    = '0;
            n_pos   = '0;
            n_lso   = '0;
            n_lro   = '0;
            n_hr    = 1'b0;
        end
    end

    always_comb begin
        n_rsp                 = '0;
        n_rsp.name_byte_valid = name_byte;
        n_rsp.name_byte       = name_byte ? b : 8'h00;
        if (commit) begin
            n_rsp.record_event     = EV_COMMIT;
            n_rsp.record_offset    = 32'(r_lso);
            n_rsp.name_length      = 8'(commit_len);
            n_rsp.prior_size_valid = r_hr;
            n_rsp.prior_size       = r_hr ? 32'(r_lso - r_lro) : 32'h0;
        end else if (overflow) begin
            n_rsp.record_event  = EV_DISCARD;
            n_rsp.record_offset = 32'(r_lso);
        end else begin
            n_rsp.record_event = EV_NONE;
        end
        if (eot && (r_hr || commit)) begin
            n_rsp.final_size_valid = 1'b1;
            n_rsp.final_size       = 32'(pos_inc - lro_after);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_KEYWORD;
            r_ki        <= '0;
            r_cl        <= '0;
            r_pos       <= '0;
            r_lso       <= '0;
            r_lro       <= '0;
            r_hr        <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_phase <= n_phase;
                r_ki    <= n_ki;
                r_cl    <= n_cl;
                r_pos   <= n_pos;
                r_lso   <= n_lso;
                r_lro   <= n_lro;
                r_hr    <= n_hr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_req;
        end
        if (fire) begin
            r_rsp <= n_rsp;
        end
    end

    a_discard_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_rsp.record_event == EV_DISCARD)) |-> r_rsp.name_byte_valid)
        else $error("discard event without a name byte");

    a_prior_only_on_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rsp.prior_size_valid) |-> (r_rsp.record_event == EV_COMMIT))
        else $error("prior size reported without a commit");

    a_ki_in_keyword: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ki != '0) |-> (r_phase == PH_KEYWORD))
        else $error("keyword index set outside keyword phase");

    a_len_in_name: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cl != '0) |-> (r_phase == PH_NAME))
        else $error("name length held outside name phase");

endmodule
